// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by ltqf_checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert that a implies b in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// assert that a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== rtl/ltqf_pkg.sv =====
// ---------------------------------------------------------------------------
// ltqf_pkg
// Shared types and constants of the largest tag quad feature block.
// ---------------------------------------------------------------------------
package ltqf_pkg;

    localparam int MAX_OBJECTS = 24;
    localparam int CNT_W       = 5;
    localparam int COORD_W     = 11;
    localparam int AREA_W      = 24;
    localparam int CORDIC_STEPS = 20;
    localparam int ANG_W       = 26;
    localparam int CX_W        = 36;

    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_TAG   = 2'd2;

    localparam logic [15:0] FOCAL_RESET  = 16'd3397;
    localparam logic [11:0] CENTER_RESET = 12'd640;
    localparam logic        REG_FOCAL    = 1'b0;
    localparam logic        REG_CENTER   = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;

    // frame summary handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             found;
        logic [7:0]       id;
        t_coord [7:0]     corners;
    } t_frame;

    function automatic logic [ANG_W-1:0] atan_lut(input logic [4:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            5'd0:  v = 26'd2949120;
            5'd1:  v = 26'd1740967;
            5'd2:  v = 26'd919879;
            5'd3:  v = 26'd466945;
            5'd4:  v = 26'd234379;
            5'd5:  v = 26'd117304;
            5'd6:  v = 26'd58666;
            5'd7:  v = 26'd29335;
            5'd8:  v = 26'd14668;
            5'd9:  v = 26'd7334;
            5'd10: v = 26'd3667;
            5'd11: v = 26'd1833;
            5'd12: v = 26'd917;
            5'd13: v = 26'd458;
            5'd14: v = 26'd229;
            5'd15: v = 26'd115;
            5'd16: v = 26'd57;
            5'd17: v = 26'd29;
            5'd18: v = 26'd14;
            5'd19: v = 26'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ltqf_front.sv =====
// ---------------------------------------------------------------------------
// ltqf_front
// Counts non-empty items, computes tag area, keeps the largest tag, emits frame summary.
// ---------------------------------------------------------------------------
module ltqf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  ltqf_pkg::t_coord [7:0] i_c,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_tag_id,
    input  logic                  i_last,
    output logic                  o_fvalid,
    input  logic                  i_fstall,
    output ltqf_pkg::t_frame      o_frame
);
    // stage A: registered item, stage B: area compare
    logic                    r_av;
    ltqf_pkg::t_coord [7:0]  r_ac;
    logic [1:0]              r_akind;
    logic [7:0]              r_aid;
    logic                    r_alast;
    logic signed [23:0]      r_p [4];

    logic [ltqf_pkg::CNT_W-1:0]  r_count;
    logic                        r_have;
    logic [ltqf_pkg::AREA_W-1:0] r_best;
    ltqf_pkg::t_coord [7:0]      r_bc;
    logic [7:0]                  r_bid;
    logic                        r_fv;
    ltqf_pkg::t_frame            r_frame;

    logic signed [25:0] w_sum;
    logic [25:0]        w_mag;
    logic [23:0]        w_sat;
    logic               w_take, w_cnt, w_upd;
    logic               w_adv;

    function automatic logic [ltqf_pkg::CNT_W-1:0] CNT_W_ONE(input logic b);
        return {{(ltqf_pkg::CNT_W-1){1'b0}}, b};
    endfunction

    // stall while the summary is waiting or a frame close is in flight
    assign o_stall = r_fv || (r_av && r_alast);
    assign w_adv   = r_av && !(r_alast && r_fv);

    always_comb begin
        w_sum = 26'(r_p[0]) + 26'(r_p[1]) + 26'(r_p[2]) + 26'(r_p[3]);
        w_mag = w_sum[25] ? 26'(-w_sum) : 26'(w_sum);
        w_sat = (w_mag > 26'hFFFFFF) ? 24'hFFFFFF : w_mag[23:0];
        w_cnt = (r_akind != ltqf_pkg::KIND_EMPTY) &&
                (r_count < (ltqf_pkg::CNT_W)'(ltqf_pkg::MAX_OBJECTS));
        w_take = w_cnt && (r_akind == ltqf_pkg::KIND_TAG);
        w_upd  = w_take && (!r_have || w_sat > r_best);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av    <= 1'b0;
            r_count <= '0;
            r_have  <= 1'b0;
            r_best  <= '0;
            r_fv    <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r_av    <= 1'b1;
                r_ac    <= i_c;
                r_akind <= i_kind;
                r_aid   <= i_tag_id;
                r_alast <= i_last;
                for (int k = 0; k < 4; k++) begin
                    r_p[k] <= 24'(i_c[2*k]) * 24'(i_c[2*((k+1)%4)+1])
                            - 24'(i_c[2*k+1]) * 24'(i_c[2*((k+1)%4)]);
                end
            end else if (w_adv) begin
                r_av <= 1'b0;
            end
            if (w_adv) begin
                if (r_alast) begin
                    r_fv          <= 1'b1;
                    r_frame.count <= r_count + CNT_W_ONE(w_cnt);
                    r_frame.found <= r_have || w_take;
                    r_frame.id    <= w_upd ? r_aid : r_bid;
                    r_frame.corners <= w_upd ? r_ac : r_bc;
                    r_count <= '0;
                    r_have  <= 1'b0;
                    r_best  <= '0;
                end else begin
                    if (w_cnt) r_count <= r_count + 1'b1;
                    if (w_upd) begin
                        r_have <= 1'b1;
                        r_best <= w_sat;
                    end
                end
                if (w_upd) begin
                    r_bc  <= r_ac;
                    r_bid <= r_aid;
                end
            end
            if (r_fv && !i_fstall) r_fv <= 1'b0;
        end
    end

    assign o_fvalid = r_fv;
    assign o_frame  = r_frame;
endmodule

// ===== rtl/ltqf_back.sv =====
// ---------------------------------------------------------------------------
// ltqf_back
// Computes centroid, mean edge length and bearing for a frame summary.
// ---------------------------------------------------------------------------
module ltqf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fvalid,
    output logic             o_fstall,
    input  ltqf_pkg::t_frame i_frame,
    input  logic [15:0]      i_focal,
    input  logic [11:0]      i_center,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [4:0]       o_object_count,
    output logic             o_found,
    output logic signed [8:0]  o_best_id,
    output logic signed [12:0] o_centroid_x,
    output logic signed [12:0] o_centroid_y,
    output logic [15:0]      o_mean_edge,
    output logic signed [15:0] o_bearing
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EDGE = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_CORD = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_st;
    ltqf_pkg::t_frame r_f;
    logic [1:0]  r_edge;
    logic [4:0]  r_step;
    logic [35:0] r_rem;
    logic [17:0] r_root;
    logic [19:0] r_esum;
    logic signed [12:0] r_sx, r_sy;
    logic signed [13:0] r_dq;
    logic signed [ltqf_pkg::CX_W-1:0] r_x, r_y;
    logic signed [ltqf_pkg::ANG_W:0]  r_z;
    logic        r_cinit;
    // radicand bits fed two per step, MSB first
    logic [35:0] r_rad;

    logic signed [12:0] w_dx, w_dy;
    logic [23:0]        w_d2;
    logic [37:0]        w_trial;
    logic [35:0]        w_rem_sh;
    logic [13:0]        w_mag;
    logic signed [ltqf_pkg::ANG_W+1:0] w_ang;
    logic [17:0]        w_ar;

    function automatic ltqf_pkg::t_coord i_pick(input logic [1:0] k, input logic y);
        return r_f.corners[{k, y}];
    endfunction

    function automatic logic [21:0] r_focal_ext(input logic [15:0] f);
        return {6'd0, f};
    endfunction

    always_comb begin
        w_dx = 13'(i_pick(r_edge + 2'd1, 1'b0)) - 13'(i_pick(r_edge, 1'b0));
        w_dy = 13'(i_pick(r_edge + 2'd1, 1'b1)) - 13'(i_pick(r_edge, 1'b1));
        w_d2 = 24'(26'(w_dx * w_dx) + 26'(w_dy * w_dy));
        // restoring square root of d2<<12, two bits per step
        w_rem_sh = {r_rem[33:0], r_rad[35:34]};
        w_trial  = {2'b00, w_rem_sh} - {18'd0, r_root, 2'b01};
        w_mag = r_dq[13] ? 14'(-r_dq) : 14'(r_dq);
        w_ang = r_z[ltqf_pkg::ANG_W] ? '0 : (28'(r_z) + 28'd128);
        w_ar  = (w_ang[ltqf_pkg::ANG_W+1:8] > 20'd23040) ? 18'd23040 : 18'(w_ang >>> 8);
    end

    assign o_fstall = (r_st != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (i_fvalid) begin
                        r_f    <= i_frame;
                        r_edge <= '0;
                        r_esum <= '0;
                        r_sx <= 13'(i_frame.corners[0]) + 13'(i_frame.corners[2])
                              + 13'(i_frame.corners[4]) + 13'(i_frame.corners[6]);
                        r_sy <= 13'(i_frame.corners[1]) + 13'(i_frame.corners[3])
                              + 13'(i_frame.corners[5]) + 13'(i_frame.corners[7]);
                        r_st <= i_frame.found ? ST_EDGE : ST_OUT;
                    end
                end
                ST_EDGE: begin
                    r_rad  <= {w_d2, 12'd0};
                    r_rem  <= '0;
                    r_root <= '0;
                    r_step <= '0;
                    r_st   <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (w_trial[37]) begin
                        r_rem  <= w_rem_sh;
                        r_root <= {r_root[16:0], 1'b0};
                    end else begin
                        r_rem  <= w_trial[35:0];
                        r_root <= {r_root[16:0], 1'b1};
                    end
                    r_rad  <= {r_rad[33:0], 2'b00};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd17) begin
                        r_st <= (r_edge == 2'd3) ? ST_CORD : ST_EDGE;
                        r_edge <= r_edge + 2'd1;
                        r_dq <= 14'(r_sx) - 14'(i_center);
                        r_step <= '0;
                    end
                end
                default: ;
            endcase
            case (r_st)
                ST_CORD: begin
                    if (r_step == 5'd0 && !r_cinit) begin
                        r_x <= (ltqf_pkg::CX_W)'({r_focal_ext(i_focal), 14'd0});
                        r_y <= (ltqf_pkg::CX_W)'({w_mag, 16'd0});
                        r_z <= '0;
                        r_cinit <= 1'b1;
                    end else begin
                        if (r_y > 0) begin
                            r_x <= r_x + (r_y >>> r_step);
                            r_y <= r_y - (r_x >>> r_step);
                            r_z <= r_z + (ltqf_pkg::ANG_W+1)'(ltqf_pkg::atan_lut(r_step));
                        end else if (r_y < 0) begin
                            r_x <= r_x - (r_y >>> r_step);
                            r_y <= r_y + (r_x >>> r_step);
                            r_z <= r_z - (ltqf_pkg::ANG_W+1)'(ltqf_pkg::atan_lut(r_step));
                        end
                        r_step <= r_step + 5'd1;
                        if (r_step == 5'd19) r_st <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_object_count <= r_f.count;
                        o_found        <= r_f.found;
                        o_best_id      <= r_f.found ? {1'b0, r_f.id} : 9'h1FF;
                        o_centroid_x   <= r_f.found ? r_sx : '0;
                        o_centroid_y   <= r_f.found ? r_sy : '0;
                        o_mean_edge    <= r_f.found ? 16'((r_esum + 20'd8) >> 4) : '0;
                        o_bearing      <= !r_f.found ? '0 :
                                          (r_dq[13] ? -16'(w_ar) : 16'(w_ar));
                        r_st <= ST_IDLE;
                    end
                end
                default: ;
            endcase
            if (r_st == ST_OUT && (!o_valid || !i_stall)) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            if (r_st == ST_SQRT && r_step == 5'd17)
                r_esum <= r_esum + 20'(w_trial[37] ? {r_root[16:0], 1'b0}
                                                   : {r_root[16:0], 1'b1});
            if (r_st != ST_CORD) r_cinit <= 1'b0;
        end
    end
endmodule

// ===== rtl/largest_tag_quad_features.sv =====
// Throughput: one item per cycle in a frame unless a summary waits or a frame closes;
// the front stalls while a summary waits for the back end, which takes no new frame
// until its result is out: it runs the edge roots in turn on a shared square root unit,
// then the CORDIC bearing steps (both skipped when no tag is found), then the output.
// Reset (synchronous, active low) clears the frame state, the pending frame summary and
// restores focal_length 3397 and image_center 640.
// ---------------------------------------------------------------------------
// largest_tag_quad_features
// Top level: config registers, front classifier, back feature unit.
// ---------------------------------------------------------------------------
module largest_tag_quad_features (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [10:0] i_corner0_x,
    input  logic signed [10:0] i_corner0_y,
    input  logic signed [10:0] i_corner1_x,
    input  logic signed [10:0] i_corner1_y,
    input  logic signed [10:0] i_corner2_x,
    input  logic signed [10:0] i_corner2_y,
    input  logic signed [10:0] i_corner3_x,
    input  logic signed [10:0] i_corner3_y,
    input  logic [1:0]         i_kind,
    input  logic [7:0]         i_tag_id,
    input  logic               i_last,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [4:0]         o_object_count,
    output logic               o_found,
    output logic signed [8:0]  o_best_id,
    output logic signed [12:0] o_centroid_x,
    output logic signed [12:0] o_centroid_y,
    output logic [15:0]        o_mean_edge,
    output logic signed [15:0] o_bearing
);
    logic [15:0] r_focal;
    logic [11:0] r_center;
    ltqf_pkg::t_coord [7:0] w_c;
    ltqf_pkg::t_frame w_frame;
    logic w_fv, w_fs;

    assign w_c = {i_corner3_y, i_corner3_x, i_corner2_y, i_corner2_x,
                  i_corner1_y, i_corner1_x, i_corner0_y, i_corner0_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal  <= ltqf_pkg::FOCAL_RESET;
            r_center <= ltqf_pkg::CENTER_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == ltqf_pkg::REG_FOCAL) r_focal <= i_cfg_data;
            else r_center <= i_cfg_data[11:0];
        end
    end

    ltqf_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_c(w_c), .i_kind, .i_tag_id, .i_last,
        .o_fvalid(w_fv), .i_fstall(w_fs), .o_frame(w_frame)
    );

    ltqf_back u_back (
        .i_clk, .i_rst_n, .i_fvalid(w_fv), .o_fstall(w_fs), .i_frame(w_frame),
        .i_focal(r_focal), .i_center(r_center),
        .o_valid, .i_stall, .o_object_count, .o_found, .o_best_id,
        .o_centroid_x, .o_centroid_y, .o_mean_edge, .o_bearing
    );
endmodule

// ===== rtl/ltqf_checker.sv =====
// ---------------------------------------------------------------------------
// ltqf_checker
// Port-level checks of the largest tag quad feature block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ltqf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_found,
    input logic signed [8:0]  o_best_id,
    input logic [4:0]         o_object_count,
    input logic [15:0]        o_mean_edge
);
    `ASSERT_IMPL(a_none_id, i_clk, i_rst_n, o_valid && !o_found, o_best_id == -9'sd1)
    `ASSERT_IMPL(a_found_cnt, i_clk, i_rst_n, o_valid && o_found, o_object_count != 5'd0)
    `ASSERT_IMPL(a_none_edge, i_clk, i_rst_n, o_valid && !o_found, o_mean_edge == 16'd0)
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
endmodule

bind largest_tag_quad_features ltqf_checker u_chk (.*);
